// File: rtl/pzf_pkg.sv
// Shared types and constants for the point z-buffer projection and fill core.
// No dependencies; every other file in rtl/ imports this package.
package pzf_pkg;

  localparam int IMG_WIDTH_DEF   = 128;
  localparam int IMG_HEIGHT_DEF  = 128;
  localparam int QUEUE_DEPTH_DEF = 65536;

  // Pixel coordinates travel at the widest image size the core supports.
  localparam int COORD_W        = 10;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 54;
  localparam int CMD_FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_PROJECT = 2'd1,
    FUNC_FILL    = 2'd2,
    FUNC_READ    = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL_COEFS   = 3'd0,
    REG_ROW_COEFS   = 3'd1,
    REG_DEPTH_COEFS = 3'd2,
    REG_BACKGROUND  = 3'd3,
    REG_FILL_LIMIT  = 3'd4
  } reg_index_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    func_t               func;
    logic                in_range;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic signed [31:0]  depth;
  } cmd_t;

  typedef enum logic [4:0] {
    B_INIT,
    B_IDLE,
    B_CLEAR,
    B_PROJ,
    B_PROJ_W,
    B_READ,
    B_READ_W,
    B_SEED,
    B_SEED_W,
    B_SNB,
    B_SNB_W,
    B_POP,
    B_POP_W,
    B_PCHK,
    B_NB,
    B_NB_W,
    B_DIVST,
    B_DIV,
    B_DIVFIN,
    B_NORM,
    B_NORM_W
  } back_state_t;

endpackage

// File: rtl/pzf_front.sv
// Front end: accepts items, projects points through the coefficient rows.
// Depends on pzf_pkg; feeds classified commands to pzf_cmd_fifo.
module pzf_front #(
  parameter int IMG_WIDTH  = pzf_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = pzf_pkg::IMG_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          func,
  input  logic signed [23:0]  point_x,
  input  logic signed [23:0]  point_y,
  input  logic signed [23:0]  point_z,
  input  logic [6:0]          read_row,
  input  logic [6:0]          read_col,
  input  logic [53:0]         col_coefs,
  input  logic [53:0]         row_coefs,
  input  logic [53:0]         depth_coefs,
  input  logic                init_done,
  input  logic                cmd_full,
  output logic                cmd_push,
  output pzf_pkg::cmd_t       cmd
);
  import pzf_pkg::*;

  logic adv;
  logic v0, v1, v2, v3;

  logic [1:0]         s0_func, s1_func, s2_func;
  logic [6:0]         s0_rr, s0_rc, s1_rr, s1_rc, s2_rr, s2_rc;
  logic signed [23:0] s0_pt [3];
  logic signed [41:0] s1_prod [3][3];
  logic signed [43:0] s2_sum [3];
  logic [53:0]        coefs [3];

  logic signed [19:0] qc, qr;
  logic signed [27:0] qd;
  logic               upc, upr, upd;
  logic signed [20:0] rc21, rr21;
  logic signed [28:0] rd29;
  logic signed [22:0] col_s, row_s;
  logic               proj_in, read_in;
  cmd_t               cmd_next;

  assign adv      = !v3 || !cmd_full;
  assign in_ready = adv && init_done;
  assign cmd_push = v3 && !cmd_full;

  assign coefs[0] = col_coefs;
  assign coefs[1] = row_coefs;
  assign coefs[2] = depth_coefs;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid && init_done;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_func  <= func;
      s0_rr    <= read_row;
      s0_rc    <= read_col;
      s0_pt[0] <= point_x;
      s0_pt[1] <= point_y;
      s0_pt[2] <= point_z;
      s1_func  <= s0_func;
      s1_rr    <= s0_rr;
      s1_rc    <= s0_rc;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s1_prod[i][j] <= 42'(s0_pt[j]) * 42'($signed(coefs[i][18*j +: 18]));
        end
      end
      s2_func <= s1_func;
      s2_rr   <= s1_rr;
      s2_rc   <= s1_rc;
      for (int i = 0; i < 3; i++) begin
        s2_sum[i] <= 44'(s1_prod[i][0]) + 44'(s1_prod[i][1]) + 44'(s1_prod[i][2]);
      end
      cmd <= cmd_next;
    end
  end

  // Round to nearest, ties to even, then place on the pixel grid.
  always_comb begin
    qc   = s2_sum[0][43:24];
    qr   = s2_sum[1][43:24];
    qd   = s2_sum[2][43:16];
    upc  = (s2_sum[0][23:0] > 24'h800000) ||
           ((s2_sum[0][23:0] == 24'h800000) && qc[0]);
    upr  = (s2_sum[1][23:0] > 24'h800000) ||
           ((s2_sum[1][23:0] == 24'h800000) && qr[0]);
    upd  = (s2_sum[2][15:0] > 16'h8000) ||
           ((s2_sum[2][15:0] == 16'h8000) && qd[0]);
    rc21 = 21'(qc) + $signed({20'd0, upc});
    rr21 = 21'(qr) + $signed({20'd0, upr});
    rd29 = 29'(qd) + $signed({28'd0, upd});
    col_s = $signed(23'(IMG_WIDTH / 2)) + 23'(rc21);
    row_s = $signed(23'(IMG_HEIGHT / 2)) - 23'(rr21);
    proj_in = !col_s[22] && (col_s < $signed(23'(IMG_WIDTH))) &&
              !row_s[22] && (row_s < $signed(23'(IMG_HEIGHT)));
    read_in = (11'(s2_rr) < 11'(IMG_HEIGHT)) && (11'(s2_rc) < 11'(IMG_WIDTH));

    cmd_next.func  = func_t'(s2_func);
    cmd_next.depth = 32'(rd29);
    if (func_t'(s2_func) == FUNC_READ) begin
      cmd_next.in_range = read_in;
      cmd_next.row      = COORD_W'(s2_rr);
      cmd_next.col      = COORD_W'(s2_rc);
    end else begin
      cmd_next.in_range = proj_in;
      cmd_next.row      = row_s[COORD_W-1:0];
      cmd_next.col      = col_s[COORD_W-1:0];
    end
  end

endmodule

// File: rtl/pzf_cmd_fifo.sv
// Short command queue between the front and back ends.
// Depends on pzf_pkg for the command type.
module pzf_cmd_fifo #(
  parameter int DEPTH = pzf_pkg::CMD_FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pzf_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output pzf_pkg::cmd_t dout,
  output logic          empty
);
  import pzf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// File: rtl/pzf_back.sv
// Back end: depth, level and fill-queue memories and the command sequencer.
// Depends on pzf_pkg; takes commands from pzf_cmd_fifo.
module pzf_back #(
  parameter int IMG_WIDTH   = pzf_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT  = pzf_pkg::IMG_HEIGHT_DEF,
  parameter int QUEUE_DEPTH = pzf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  pzf_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  logic signed [31:0] background_depth,
  input  logic [7:0]         fill_limit,
  output logic               init_done,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pixel_depth,
  output logic               covered,
  output logic               accepted,
  output logic               overflow
);
  import pzf_pkg::*;

  localparam int RB = $clog2(IMG_HEIGHT);
  localparam int CB = $clog2(IMG_WIDTH);
  localparam int AW = RB + CB;
  localparam int QB = $clog2(QUEUE_DEPTH);
  localparam int QW = RB + CB + 8;

  back_state_t state, state_next;

  logic [7:0]  level_mem [2**AW];
  logic [31:0] depth_mem [2**AW];
  logic [QW-1:0] queue_mem [QUEUE_DEPTH];

  logic [7:0]    level_q;
  logic [31:0]   depth_q;
  logic [QW-1:0] queue_q;

  logic [AW-1:0] lv_raddr, lv_waddr, dp_raddr, dp_waddr;
  logic          lv_we, dp_we, q_we;
  logic [7:0]    lv_wdata;
  logic [31:0]   dp_wdata;
  logic [QW-1:0] q_wdata;

  cmd_t          cmd_r;
  logic [RB-1:0] cur_row, nb_row, q_row;
  logic [CB-1:0] cur_col, nb_col, q_col;
  logic [7:0]    cur_lv, q_lv;
  logic [1:0]    nb_k;
  logic [QB:0]   head, tail;
  logic          ovf;

  logic signed [33:0] sum;
  logic [2:0]         cnt;
  logic [33:0]        dq;
  logic [1:0]         rem;
  logic [5:0]         div_cnt;
  logic               neg;

  logic          sweep_last, seed_last, q_full, q_nonempty, pop_ok;
  logic          push_req, nb_take, proj_win, rd_hit;
  logic [2:0]    div_t;
  logic          div_ge;
  logic signed [34:0] q_floor, q_rnd;
  logic [2:0]    fin_r;
  logic [3:0]    fin_twice;
  logic          fin_up;
  logic [31:0]   div_result;

  assign init_done  = (state != B_INIT);
  assign sweep_last = (cur_row == RB'(IMG_HEIGHT - 1)) && (cur_col == CB'(IMG_WIDTH - 1));
  assign seed_last  = (cur_row == RB'(IMG_HEIGHT - 2)) && (cur_col == CB'(IMG_WIDTH - 2));
  assign q_full     = (tail >= (QB+1)'(QUEUE_DEPTH));
  assign q_nonempty = (head < tail);

  assign q_row = queue_q[QW-1 -: RB];
  assign q_col = queue_q[CB+7:8];
  assign q_lv  = queue_q[7:0];
  assign pop_ok = (q_row != '0) && (q_row < RB'(IMG_HEIGHT - 1)) &&
                  (q_col != '0) && (q_col < CB'(IMG_WIDTH - 1)) &&
                  (q_lv < fill_limit);

  assign nb_take  = (level_q != 8'd0) && (level_q <= cur_lv);
  assign proj_win = cmd_r.in_range &&
                    ((level_q == 8'd0) || (cmd_r.depth > $signed(depth_q)));
  assign rd_hit   = cmd_r.in_range && (level_q != 8'd0);

  // Neighbor order: left, right, up, down.
  always_comb begin
    nb_row = cur_row;
    nb_col = cur_col;
    case (nb_k)
      2'd0:    nb_col = cur_col - CB'(1);
      2'd1:    nb_col = cur_col + CB'(1);
      2'd2:    nb_row = cur_row - RB'(1);
      default: nb_row = cur_row + RB'(1);
    endcase
  end

  // One restoring step of the small divider, and the final rounding.
  always_comb begin
    div_t  = {rem, dq[33]};
    div_ge = (div_t >= cnt);
    if (!neg) begin
      q_floor = $signed({1'b0, dq});
      fin_r   = {1'b0, rem};
    end else if (rem == 2'd0) begin
      q_floor = -$signed({1'b0, dq});
      fin_r   = 3'd0;
    end else begin
      q_floor = -$signed({1'b0, dq}) - 35'sd1;
      fin_r   = cnt - {1'b0, rem};
    end
    fin_twice  = {fin_r, 1'b0};
    fin_up     = (fin_twice > {1'b0, cnt}) ||
                 ((fin_twice == {1'b0, cnt}) && q_floor[0]);
    q_rnd      = q_floor + $signed({34'd0, fin_up});
    div_result = (cnt == 3'd0) ? background_depth : q_rnd[31:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_INIT:   if (sweep_last) state_next = B_IDLE;
      B_IDLE: begin
        if (cmd_valid && !out_valid) begin
          unique case (cmd.func)
            FUNC_CLEAR:   state_next = B_CLEAR;
            FUNC_PROJECT: state_next = B_PROJ;
            FUNC_FILL:    state_next = B_SEED;
            FUNC_READ:    state_next = B_READ;
            default:      state_next = B_IDLE;
          endcase
        end
      end
      B_CLEAR:  if (sweep_last) state_next = B_IDLE;
      B_PROJ:   state_next = B_PROJ_W;
      B_PROJ_W: state_next = B_IDLE;
      B_READ:   state_next = B_READ_W;
      B_READ_W: state_next = B_IDLE;
      B_SEED:   state_next = B_SEED_W;
      B_SEED_W: begin
        if (level_q != 8'd0) state_next = seed_last ? B_POP : B_SEED;
        else state_next = B_SNB;
      end
      B_SNB:    state_next = B_SNB_W;
      B_SNB_W: begin
        if ((level_q != 8'd0) || (nb_k == 2'd3)) state_next = seed_last ? B_POP : B_SEED;
        else state_next = B_SNB;
      end
      B_POP:    state_next = q_nonempty ? B_POP_W : B_NORM;
      B_POP_W:  state_next = pop_ok ? B_PCHK : B_POP;
      B_PCHK:   state_next = (level_q != 8'd0) ? B_POP : B_NB;
      B_NB:     state_next = B_NB_W;
      B_NB_W:   state_next = (nb_k == 2'd3) ? B_DIVST : B_NB;
      B_DIVST:  state_next = B_DIV;
      B_DIV:    if (div_cnt == 6'd33) state_next = B_DIVFIN;
      B_DIVFIN: state_next = B_POP;
      B_NORM:   state_next = B_NORM_W;
      B_NORM_W: state_next = sweep_last ? B_IDLE : B_NORM;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    lv_raddr = {cur_row, cur_col};
    dp_raddr = {cur_row, cur_col};
    lv_waddr = {cur_row, cur_col};
    dp_waddr = {cur_row, cur_col};
    lv_we    = 1'b0;
    dp_we    = 1'b0;
    lv_wdata = 8'd0;
    dp_wdata = div_result;
    push_req = 1'b0;
    q_wdata  = {cur_row, cur_col, 8'd1};
    cmd_pop  = 1'b0;
    unique case (state)
      B_INIT, B_CLEAR: lv_we = 1'b1;
      B_IDLE:  cmd_pop = cmd_valid && !out_valid;
      B_PROJ, B_READ: begin
        lv_raddr = {cmd_r.row[RB-1:0], cmd_r.col[CB-1:0]};
        dp_raddr = {cmd_r.row[RB-1:0], cmd_r.col[CB-1:0]};
      end
      B_PROJ_W: begin
        lv_waddr = {cmd_r.row[RB-1:0], cmd_r.col[CB-1:0]};
        dp_waddr = {cmd_r.row[RB-1:0], cmd_r.col[CB-1:0]};
        lv_we    = proj_win;
        dp_we    = proj_win;
        lv_wdata = 8'd1;
        dp_wdata = cmd_r.depth;
      end
      B_SNB, B_NB: begin
        lv_raddr = {nb_row, nb_col};
        dp_raddr = {nb_row, nb_col};
      end
      B_SNB_W: push_req = (level_q != 8'd0);
      B_POP_W: lv_raddr = {q_row, q_col};
      B_PCHK: begin
        lv_we    = (level_q == 8'd0);
        lv_wdata = cur_lv + 8'd1;
      end
      B_NB_W: begin
        push_req = !nb_take;
        q_wdata  = {nb_row, nb_col, cur_lv + 8'd1};
      end
      B_DIVFIN: dp_we = 1'b1;
      B_NORM_W: begin
        lv_we    = (level_q != 8'd0);
        lv_wdata = 8'd1;
      end
      default: ;
    endcase
    q_we = push_req && !q_full;
  end

  always_ff @(posedge clk) begin
    level_q <= level_mem[lv_raddr];
    if (lv_we) level_mem[lv_waddr] <= lv_wdata;
  end

  always_ff @(posedge clk) begin
    depth_q <= depth_mem[dp_raddr];
    if (dp_we) depth_mem[dp_waddr] <= dp_wdata;
  end

  always_ff @(posedge clk) begin
    queue_q <= queue_mem[head[QB-1:0]];
    if (q_we) queue_mem[tail[QB-1:0]] <= q_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      cur_row   <= '0;
      cur_col   <= '0;
      head      <= '0;
      tail      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (q_we) tail <= tail + (QB+1)'(1);
      if (push_req && q_full) ovf <= 1'b1;
      unique case (state)
        B_INIT, B_CLEAR, B_NORM_W: begin
          if (cur_col == CB'(IMG_WIDTH - 1)) begin
            cur_col <= '0;
            cur_row <= sweep_last ? '0 : cur_row + RB'(1);
          end else begin
            cur_col <= cur_col + CB'(1);
          end
          if (sweep_last && (state != B_INIT)) begin
            out_valid   <= 1'b1;
            pixel_depth <= '0;
            covered     <= 1'b0;
            accepted    <= 1'b0;
            overflow    <= ovf;
          end
        end
        B_IDLE: begin
          if (cmd_pop) begin
            cmd_r <= cmd;
            if (cmd.func == FUNC_CLEAR) begin
              head    <= '0;
              tail    <= '0;
              ovf     <= 1'b0;
              cur_row <= '0;
              cur_col <= '0;
            end else if (cmd.func == FUNC_FILL) begin
              head    <= '0;
              tail    <= '0;
              cur_row <= RB'(1);
              cur_col <= CB'(1);
            end
          end
        end
        B_PROJ_W: begin
          out_valid   <= 1'b1;
          pixel_depth <= '0;
          covered     <= 1'b0;
          accepted    <= proj_win;
          overflow    <= ovf;
        end
        B_READ_W: begin
          out_valid   <= 1'b1;
          pixel_depth <= rd_hit ? $signed(depth_q) : background_depth;
          covered     <= rd_hit;
          accepted    <= 1'b0;
          overflow    <= ovf;
        end
        B_SEED_W, B_SNB_W: begin
          nb_k <= (state == B_SEED_W) ? 2'd0 : nb_k + 2'd1;
          if ((level_q != 8'd0) || ((state == B_SNB_W) && (nb_k == 2'd3))) begin
            if (cur_col == CB'(IMG_WIDTH - 2)) begin
              cur_col <= CB'(1);
              cur_row <= cur_row + RB'(1);
            end else begin
              cur_col <= cur_col + CB'(1);
            end
          end
        end
        B_POP: begin
          if (q_nonempty) begin
            head <= head + (QB+1)'(1);
          end else begin
            cur_row <= '0;
            cur_col <= '0;
          end
        end
        B_POP_W: begin
          cur_row <= q_row;
          cur_col <= q_col;
          cur_lv  <= q_lv;
        end
        B_PCHK: begin
          sum  <= '0;
          cnt  <= 3'd0;
          nb_k <= 2'd0;
        end
        B_NB_W: begin
          if (nb_take) begin
            sum <= sum + 34'($signed(depth_q));
            cnt <= cnt + 3'd1;
          end
          nb_k <= nb_k + 2'd1;
        end
        B_DIVST: begin
          neg     <= sum[33];
          dq      <= sum[33] ? 34'(-sum) : 34'(sum);
          rem     <= 2'd0;
          div_cnt <= 6'd0;
        end
        B_DIV: begin
          rem     <= div_ge ? 2'(div_t - cnt) : div_t[1:0];
          dq      <= {dq[32:0], div_ge};
          div_cnt <= div_cnt + 6'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/point_zbuffer_project_fill_core.sv
// Top level of the point z-buffer projection and hole-fill core.
// Depends on pzf_pkg, pzf_front, pzf_cmd_fifo and pzf_back.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------------
//   input   | in_valid / in_ready   | func, point_x/y/z, read_row, read_col
//   result  | out_valid / out_ready | pixel_depth, covered, accepted, overflow
//   config  | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// A point passes through the front projection pipeline registers (input, product,
// sum and command) and then the back end, paced by the read-then-write of the level
// and depth memories and the single output register; reads cost the same.
// Clear sweeps every pixel of the level memory. Fill scans every interior pixel,
// then runs the queue (dominated by the bit-serial averaging divider), then one
// more sweep over every pixel to normalize levels.
// After reset a clearing pass over every pixel runs and in_ready stays low until
// it ends. A stalled result holds the back end; the command queue keeps the front
// taking items until it fills.
module point_zbuffer_project_fill_core #(
  parameter int IMG_WIDTH   = pzf_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT  = pzf_pkg::IMG_HEIGHT_DEF,
  parameter int QUEUE_DEPTH = pzf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         func,
  input  logic signed [23:0]                 point_x,
  input  logic signed [23:0]                 point_y,
  input  logic signed [23:0]                 point_z,
  input  logic [6:0]                         read_row,
  input  logic [6:0]                         read_col,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [31:0]                 pixel_depth,
  output logic                               covered,
  output logic                               accepted,
  output logic                               overflow,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pzf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pzf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pzf_pkg::*;

  logic [53:0]        col_coefs, row_coefs, depth_coefs;
  logic signed [31:0] background_depth;
  logic [7:0]         fill_limit;

  logic init_done, cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;

  // The user must write config only while idle; the core does not enforce it and always takes them.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_coefs        <= 54'd65536;
      row_coefs        <= 54'd17179869184;
      depth_coefs      <= 54'd4503599627370496;
      background_depth <= '0;
      fill_limit       <= 8'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COL_COEFS:   col_coefs        <= cfg_data;
        REG_ROW_COEFS:   row_coefs        <= cfg_data;
        REG_DEPTH_COEFS: depth_coefs      <= cfg_data;
        REG_BACKGROUND:  background_depth <= $signed(cfg_data[31:0]);
        REG_FILL_LIMIT:  fill_limit       <= cfg_data[7:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Project and classify each item.
  pzf_front #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .read_row    (read_row),
    .read_col    (read_col),
    .col_coefs   (col_coefs),
    .row_coefs   (row_coefs),
    .depth_coefs (depth_coefs),
    .init_done   (init_done),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  // Decouple the two halves so each can stall on its own.
  pzf_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  // Carry out commands against the image memories.
  pzf_back #(
    .IMG_WIDTH   (IMG_WIDTH),
    .IMG_HEIGHT  (IMG_HEIGHT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cmd_valid        (!cmd_empty),
    .cmd              (cmd_out),
    .cmd_pop          (cmd_pop),
    .background_depth (background_depth),
    .fill_limit       (fill_limit),
    .init_done        (init_done),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .pixel_depth      (pixel_depth),
    .covered          (covered),
    .accepted         (accepted),
    .overflow         (overflow)
  );

  a_no_input_during_init: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> !in_ready)
    else $error("input taken during the reset clearing pass");

  a_fifo_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd_full |-> !cmd_push)
    else $error("command pushed into a full queue");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(covered && accepted))
    else $error("result flags both a read hit and a projected point");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty && !out_valid)
    else $error("command popped while queue empty or result pending");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for point_zbuffer_project_fill_core: directed and random
// clear/project/fill/read traffic against an in-bench z-buffer predictor.
// Depends on pzf_pkg and the core RTL only.
module testbench;
  import pzf_pkg::*;

  localparam int W = 128;
  localparam int H = 128;
  localparam int NPIX = W * H;
  localparam int QDEPTH = 65536;
  // Longest quiet stretch allowed: a fill pass over the whole image runs with
  // nothing moving on any channel.
  localparam int WATCHDOG = 5000000;
  // Long enough to outlast the clear that it starts beside and then back up the core.
  localparam int LONG_HOLD = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = '0;
  logic signed [23:0] point_x = '0;
  logic signed [23:0] point_y = '0;
  logic signed [23:0] point_z = '0;
  logic [6:0] read_row = '0;
  logic [6:0] read_col = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] pixel_depth;
  logic covered;
  logic accepted;
  logic overflow;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int src_idle = 35;
  int dst_idle = 76;
  int n_sent = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  point_zbuffer_project_fill_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .read_row(read_row), .read_col(read_col),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_depth(pixel_depth), .covered(covered), .accepted(accepted),
    .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Z-buffer predictor plus the queue of pixel results still owed by the core.
  class zbuf_scoreboard;
    typedef struct {
      logic signed [31:0] depth;
      bit cov;
      bit acc;
      bit ovf;
    } pixel_result_t;

    logic [53:0] coefs[3];
    logic signed [31:0] bg;
    int unsigned fill_lim;
    int depth_mem[NPIX];
    byte unsigned level_mem[NPIX];
    int unsigned work_q[QDEPTH];
    int unsigned q_head, q_tail;
    bit ovf;
    pixel_result_t pending_q[$];
    int hit_pix[$];
    int errors, n_checked, n_landed, n_points, n_cov_reads, n_fills;

    function new();
      coefs[0] = 54'd65536;
      coefs[1] = 54'd17179869184;
      coefs[2] = 54'd4503599627370496;
      bg = 0;
      fill_lim = 10;
      foreach (level_mem[i]) begin
        level_mem[i] = 0;
        depth_mem[i] = 0;
      end
      q_head = 0;
      q_tail = 0;
      ovf = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [53:0] d);
      case (idx)
        REG_COL_COEFS:   coefs[0] = d;
        REG_ROW_COEFS:   coefs[1] = d;
        REG_DEPTH_COEFS: coefs[2] = d;
        REG_BACKGROUND:  bg = d[31:0];
        REG_FILL_LIMIT:  fill_lim = 32'(d[7:0]);
        default: ;
      endcase
    endfunction

    // Divide rounding to nearest, ties to even; den > 0.
    function longint div_even(longint num, longint den);
      longint q, r;
      q = num / den;
      r = num % den;
      if (r < 0) begin
        q -= 1;
        r += den;
      end
      if (2 * r > den || (2 * r == den && q[0])) q += 1;
      return q;
    endfunction

    function longint dot_row(logic [53:0] c, longint x, longint y, longint z);
      return x * longint'($signed(c[17:0])) + y * longint'($signed(c[35:18]))
           + z * longint'($signed(c[53:36]));
    endfunction

    function void push_work(int unsigned p, int unsigned lv);
      if (q_tail >= QDEPTH) begin
        ovf = 1;
        return;
      end
      work_q[q_tail] = (p << 8) | (lv & 255);
      q_tail++;
    endfunction

    function void run_fill();
      int unsigned p, lv, e, q;
      int r, c, k;
      longint sum, cnt;
      int unsigned nb[4];
      q_head = 0;
      q_tail = 0;
      for (r = 1; r < H - 1; r++)
        for (c = 1; c < W - 1; c++) begin
          p = r * W + c;
          if (level_mem[p] == 0 && (level_mem[p-1] != 0 || level_mem[p+1] != 0 ||
              level_mem[p-W] != 0 || level_mem[p+W] != 0))
            push_work(p, 1);
        end
      while (q_head < q_tail) begin
        e = work_q[q_head];
        p = e >> 8;
        lv = e & 255;
        q_head++;
        if (p >= NPIX) continue;
        r = p / W;
        c = p % W;
        if (level_mem[p] != 0 || !(r > 0 && r < H - 1 && c > 0 && c < W - 1) ||
            lv >= fill_lim)
          continue;
        level_mem[p] = 8'(lv + 1);
        nb[0] = p - 1;
        nb[1] = p + 1;
        nb[2] = p - W;
        nb[3] = p + W;
        sum = 0;
        cnt = 0;
        for (k = 0; k < 4; k++) begin
          q = nb[k];
          if (level_mem[q] != 0 && level_mem[q] <= lv) begin
            sum += longint'(depth_mem[q]);
            cnt++;
          end else begin
            push_work(q, lv + 1);
          end
        end
        depth_mem[p] = (cnt > 0) ? int'(div_even(sum, cnt)) : bg;
      end
      foreach (level_mem[i])
        if (level_mem[i] != 0) level_mem[i] = 1;
    endfunction

    function void note_input(func_t f, logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [23:0] z, logic [6:0] rr, logic [6:0] rc);
      pixel_result_t res;
      longint col, row, d;
      int p;
      res = '{depth: 0, cov: 0, acc: 0, ovf: 0};
      case (f)
        FUNC_CLEAR: begin
          foreach (level_mem[i]) level_mem[i] = 0;
          q_head = 0;
          q_tail = 0;
          ovf = 0;
          hit_pix.delete();
        end
        FUNC_PROJECT: begin
          n_points++;
          col = W / 2 + div_even(dot_row(coefs[0], x, y, z), 64'sd16777216);
          row = H / 2 - div_even(dot_row(coefs[1], x, y, z), 64'sd16777216);
          d = div_even(dot_row(coefs[2], x, y, z), 64'sd65536);
          if (row >= 0 && row < H && col >= 0 && col < W) begin
            p = int'(row * W + col);
            if (level_mem[p] == 0 || d > longint'(depth_mem[p])) begin
              depth_mem[p] = int'(d);
              level_mem[p] = 1;
              res.acc = 1;
              n_landed++;
              hit_pix = {hit_pix, p};
              if (hit_pix.size() > 64) void'(hit_pix.pop_front());
            end
          end
        end
        FUNC_FILL: begin
          n_fills++;
          run_fill();
        end
        default: begin
          p = rr * W + rc;
          res.depth = bg;
          if (level_mem[p] != 0) begin
            res.depth = depth_mem[p];
            res.cov = 1;
            n_cov_reads++;
          end
        end
      endcase
      res.ovf = ovf;
      pending_q = {pending_q, res};
    endfunction

    task report_mismatch(string what, longint got, longint want);
      errors++;
      $display("MISMATCH result %0d %s: got %0d expected %0d", n_checked, what, got, want);
    endtask

    task check_result(logic signed [31:0] pd, logic cv, logic ac, logic ov);
      pixel_result_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result, depth", pd, 0);
        return;
      end
      want = pending_q.pop_front();
      if (pd !== want.depth) report_mismatch("pixel_depth", pd, want.depth);
      if (cv !== want.cov) report_mismatch("covered", cv, want.cov);
      if (ac !== want.acc) report_mismatch("accepted", ac, want.acc);
      if (ov !== want.ovf) report_mismatch("overflow", ov, want.ovf);
      n_checked++;
    endtask
  endclass

  zbuf_scoreboard sb = new();

  // Offer one item and hold it until the transfer; the idle mix follows the item count.
  task automatic send_item(func_t f, logic signed [23:0] x, logic signed [23:0] y,
                           logic signed [23:0] z, logic [6:0] rr, logic [6:0] rc);
    if (n_sent < 550) begin
      src_idle = 35;
      dst_idle = 76;
    end else if (n_sent < 1100) begin
      src_idle = 76;
      dst_idle = 35;
    end else begin
      src_idle = 0;
      dst_idle = 0;
    end
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    read_row <= rr;
    read_col <= rc;
    do @(posedge clk); while (!in_ready);
    sb.note_input(f, x, y, z, rr, rc);
    n_sent++;
  endtask

  task automatic project(int x, int y, int z);
    send_item(FUNC_PROJECT, 24'(x), 24'(y), 24'(z), 7'(x), 7'(y));
  endtask

  task automatic read_px(int r, int c);
    send_item(FUNC_READ, 24'($urandom), 24'($urandom), 24'($urandom), 7'(r), 7'(c));
  endtask

  task automatic command(func_t f);
    send_item(f, 24'($urandom), 24'($urandom), 24'($urandom), 7'($urandom), 7'($urandom));
  endtask

  // Drop valid and wait until every owed result has come back, plus a margin.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Drop valid after each write so the next write starts clean.
  task automatic write_reg(reg_index_t idx, logic [53:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, d);
    @(posedge clk);
  endtask

  function automatic logic [53:0] pack3(int a, int b, int c);
    return {c[17:0], b[17:0], a[17:0]};
  endfunction

  function automatic logic signed [23:0] rand_coord(int span);
    if ($urandom_range(9) == 0) return 24'($urandom);
    return 24'(int'($urandom_range(2 * span)) - span);
  endfunction

  // Mostly projections and reads; a fill lands mid-phase when asked for.
  task automatic random_items(int count, int span, bit with_fill);
    int k, sel, p;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(999);
      if (with_fill && k == count / 2) begin
        command(FUNC_FILL);
      end else if (sel < 5) begin
        command(FUNC_CLEAR);
      end else if (sel < 620) begin
        project(rand_coord(span), rand_coord(span),
                ($urandom_range(2) == 0) ? 24'($urandom) : rand_coord(span * 4));
      end else if (sb.hit_pix.size() != 0 && sel < 810) begin
        p = sb.hit_pix[$urandom_range(sb.hit_pix.size() - 1)];
        read_px(p / W, p % W);
      end else begin
        read_px($urandom_range(127), $urandom_range(127));
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when asked; check every transfer.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(pixel_depth, covered, accepted, overflow);
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= dst_idle);
    end
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG) begin
      $display("watchdog: no transfer for %0d cycles, %0d results owed",
               stall_cycles, sb.pending_q.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset defaults map x to column, y to row, z to depth.
    read_px(0, 0);
    project(0, 0, 0);
    project(0, 0, -256);                 // farther, loses the depth test
    project(0, 0, 512);                  // nearer, wins
    read_px(64, 64);
    project(128, 0, 100);                // half pixel, ties to even: column 64
    project(384, 0, 100);                // 1.5 rounds to column 66
    project(-128, 128, 7);               // both ties go to zero offset
    project(63 * 256, 0, 8388607);       // right edge column
    project(-64 * 256, 0, -8388608);     // left edge column
    project(0, 64 * 256, 33);            // top row
    project(0, -63 * 256, 44);           // bottom row
    project(64 * 256, 0, 1);             // just off the right edge
    project(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    project(24'sh800000, 24'sh800000, 24'sh800000);
    project(20 * 256, -10 * 256, 1000);
    read_px(64, 66);
    read_px(64, 127);
    read_px(127, 0);
    command(FUNC_FILL);                  // default limit of ten levels
    read_px(65, 64);
    read_px(64, 70);
    read_px(74, 84);
    command(FUNC_CLEAR);
    read_px(64, 64);
    read_px(127, 127);

    // Phase 1: defaults with a shallow fill; the receiver holds off early on.
    drain();
    write_reg(REG_BACKGROUND, 54'($urandom));
    write_reg(REG_FILL_LIMIT, 54'd3);
    command(FUNC_CLEAR);
    hold_req = 1'b1;
    random_items(320, 64 * 256, 1'b1);

    // Phase 2: scaled and mixed coefficients; limit one fills nothing.
    drain();
    write_reg(REG_COL_COEFS, pack3(32768, 16384, 0));
    write_reg(REG_ROW_COEFS, pack3(-8192, 32768, 0));
    write_reg(REG_DEPTH_COEFS, pack3(-4096, 0, 65536));
    write_reg(REG_BACKGROUND, 54'(32'h8000_0000));
    write_reg(REG_FILL_LIMIT, 54'd1);
    command(FUNC_CLEAR);
    random_items(320, 128 * 256, 1'b1);

    // Phase 3: extreme coefficients, top background, fill limit 254 on an empty image.
    drain();
    write_reg(REG_COL_COEFS, pack3(18'h1FFFF, 18'h1FFFF, 18'h1FFFF));
    write_reg(REG_ROW_COEFS, pack3(18'h20000, 18'h20000, 18'h20000));
    write_reg(REG_DEPTH_COEFS, pack3(18'h1FFFF, 18'h20000, 18'h1FFFF));
    write_reg(REG_BACKGROUND, 54'(32'h7FFF_FFFF));
    write_reg(REG_FILL_LIMIT, 54'd254);
    command(FUNC_CLEAR);
    command(FUNC_FILL);
    random_items(320, 16 * 256, 1'b0);

    // Phase 4: random coefficients, two-level fill.
    drain();
    write_reg(REG_COL_COEFS, 54'({$urandom, $urandom}));
    write_reg(REG_ROW_COEFS, 54'({$urandom, $urandom}));
    write_reg(REG_DEPTH_COEFS, 54'({$urandom, $urandom}));
    write_reg(REG_BACKGROUND, 54'($urandom));
    write_reg(REG_FILL_LIMIT, 54'd2);
    command(FUNC_CLEAR);
    random_items(320, 32 * 256, 1'b1);

    // Phase 5: back to plain projection, no idling by now.
    drain();
    write_reg(REG_COL_COEFS, 54'd65536);
    write_reg(REG_ROW_COEFS, 54'd17179869184);
    write_reg(REG_DEPTH_COEFS, 54'd4503599627370496);
    write_reg(REG_FILL_LIMIT, 54'd5);
    command(FUNC_CLEAR);
    random_items(340, 64 * 256, 1'b0);

    drain();
    $display("summary: %0d items, %0d results checked, %0d of %0d points won a pixel",
             n_sent, sb.n_checked, sb.n_landed, sb.n_points);
    $display("summary: %0d fill passes, %0d reads hit covered pixels, %0d mismatches",
             sb.n_fills, sb.n_cov_reads, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
